FILE: rtl/array_doubly_linked_list_top_defines.svh
// Assertion macros for the linked-list block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef ARRAY_DOUBLY_LINKED_LIST_TOP_DEFINES_SVH
`define ARRAY_DOUBLY_LINKED_LIST_TOP_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define ADLL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adll assertion failed");

// Next-cycle implication, ignored during reset
`define ADLL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adll assertion failed");

`endif

FILE: rtl/adll_pkg.sv
// Shared types, constants and helpers for the linked-list block.
// No dependencies.
package adll_pkg;
    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int CNT_W  = 7;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_MISS  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] record_id;
        logic [31:0]        grade_bits;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  found_slot;
        logic [31:0] found_grade;
        logic [6:0]  element_count;
    } t_res;

    // one write port of a link memory
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    function automatic logic is_slot(input logic [LINK_W-1:0] l);
        return l < NIL;
    endfunction
endpackage

FILE: rtl/array_doubly_linked_list_top.sv
// Linked list of (id, grade) records in a 64-slot memory with a free chain.
// Insert walks to the tail, remove and search to the match, one memory read
// per list step. Full inserts, unknown requests and empty-list removes or
// searches finish in idle. The result is registered and shows in the cycle
// after the last step. Sync active-low reset empties the list.
`include "array_doubly_linked_list_top_defines.svh"
module array_doubly_linked_list_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  adll_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_valid,
    output adll_pkg::t_res o_res
);
    import adll_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_INS_POP  = 6'b000010,
        S_INS_WALK = 6'b000100,
        S_FIND     = 6'b001000,
        S_REM_A    = 6'b010000,
        S_REM_B    = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_free, n_free;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_pv, n_pv;
    logic [LINK_W-1:0] r_nx, n_nx;
    t_req              r_req, n_req;
    logic              r_valid, n_valid;
    t_res              r_res, n_res;

    t_link_wr          next_wr, prev_wr;
    logic [SLOT_W-1:0] raddr;
    logic [LINK_W-1:0] next_rd, prev_rd;
    logic              rec_we;
    logic [31:0]       id_rd, grade_rd;

    adll_link_mem u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_next_wr (next_wr),
        .i_prev_wr (prev_wr),
        .i_raddr   (raddr),
        .o_next    (next_rd),
        .o_prev    (prev_rd)
    );

    adll_rec_mem u_rec (
        .i_clk    (i_clk),
        .i_we     (rec_we),
        .i_waddr  (r_free[SLOT_W-1:0]),
        .i_wid    (r_req.record_id),
        .i_wgrade (r_req.grade_bits),
        .i_raddr  (raddr),
        .o_id     (id_rd),
        .o_grade  (grade_rd)
    );

    // sequence one transaction
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_free  = r_free;
        n_count = r_count;
        n_cur   = r_cur;
        n_pv    = r_pv;
        n_nx    = r_nx;
        n_req   = r_req;
        n_valid = 1'b0;
        n_res   = r_res;
        next_wr = '0;
        prev_wr = '0;
        raddr   = r_cur[SLOT_W-1:0];
        rec_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_res = '0;
                n_res.element_count = r_count;
                if (i_start) begin
                    n_req = i_req;
                    priority if (i_req.req_type == REQ_INSERT) begin
                        raddr = r_free[SLOT_W-1:0];
                        if (is_slot(r_free)) begin
                            n_state = S_INS_POP;
                        end else begin
                            n_res.status = STAT_FULL;
                            n_valid = 1'b1;
                        end
                    end else if (i_req.req_type == REQ_REMOVE ||
                                 i_req.req_type == REQ_SEARCH) begin
                        raddr = r_head[SLOT_W-1:0];
                        n_cur = r_head;
                        if (is_slot(r_head)) begin
                            n_state = S_FIND;
                        end else begin
                            n_res.status = STAT_MISS;
                            n_valid = 1'b1;
                        end
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_INS_POP: begin
                // pop free slot, fill it, hook at head or go find tail
                rec_we  = 1'b1;
                next_wr = '{we: 1'b1, addr: r_free[SLOT_W-1:0], data: NIL};
                prev_wr = '{we: 1'b1, addr: r_free[SLOT_W-1:0], data: NIL};
                n_free  = next_rd;
                n_nx    = r_free;
                n_count = r_count + CNT_W'(1);
                raddr   = r_head[SLOT_W-1:0];
                n_cur   = r_head;
                if (is_slot(r_head)) begin
                    n_state = S_INS_WALK;
                end else begin
                    n_head  = r_free;
                    n_res.status = STAT_DONE;
                    n_res.found_slot = r_free[5:0];
                    n_res.element_count = n_count;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INS_WALK: begin
                // advance to tail, then link the new slot after it
                if (is_slot(next_rd)) begin
                    n_cur = next_rd;
                    raddr = next_rd[SLOT_W-1:0];
                end else begin
                    next_wr = '{we: 1'b1, addr: r_cur[SLOT_W-1:0], data: r_nx};
                    prev_wr = '{we: 1'b1, addr: r_nx[SLOT_W-1:0], data: r_cur};
                    n_res.status = STAT_DONE;
                    n_res.found_slot = r_nx[5:0];
                    n_res.element_count = r_count;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                // compare id, follow next on a miss
                if (id_rd == r_req.record_id) begin
                    n_res.status = STAT_DONE;
                    n_res.found_slot = r_cur[5:0];
                    if (r_req.req_type == REQ_REMOVE) begin
                        n_pv = prev_rd;
                        n_nx = next_rd;
                        n_state = S_REM_A;
                    end else begin
                        n_res.found_grade = grade_rd;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (is_slot(next_rd)) begin
                    n_cur = next_rd;
                    raddr = next_rd[SLOT_W-1:0];
                end else begin
                    n_res.status = STAT_MISS;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REM_A: begin
                // bridge neighbors around the removed slot
                if (is_slot(r_pv)) begin
                    next_wr = '{we: 1'b1, addr: r_pv[SLOT_W-1:0], data: r_nx};
                end else begin
                    n_head = r_nx;
                end
                if (is_slot(r_nx)) begin
                    prev_wr = '{we: 1'b1, addr: r_nx[SLOT_W-1:0], data: r_pv};
                end
                n_state = S_REM_B;
            end
            S_REM_B: begin
                // push removed slot onto the free chain
                next_wr = '{we: 1'b1, addr: r_cur[SLOT_W-1:0], data: r_free};
                prev_wr = '{we: 1'b1, addr: r_cur[SLOT_W-1:0], data: NIL};
                n_free  = r_cur;
                n_count = r_count - CNT_W'(1);
                n_res.element_count = n_count;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_free  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_pv  <= n_pv;
        r_nx  <= n_nx;
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    `ADLL_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(SLOTS))
    `ADLL_ASSERT_NOW(a_free_empty_full, !is_slot(r_free), r_count == CNT_W'(SLOTS))
    `ADLL_ASSERT_NOW(a_full_status, o_valid && o_res.status == STAT_FULL,
                     o_res.element_count == CNT_W'(SLOTS))
    `ADLL_ASSERT_NXT(a_accept_progress, i_start && !o_busy, o_busy || o_valid)
endmodule

FILE: rtl/adll_link_mem.sv
// Next and prev link memories with per-entry valid bits for reset values.
// Depends on adll_pkg.
module adll_link_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  adll_pkg::t_link_wr           i_next_wr,
    input  adll_pkg::t_link_wr           i_prev_wr,
    input  logic [adll_pkg::SLOT_W-1:0]  i_raddr,
    output logic [adll_pkg::LINK_W-1:0]  o_next,
    output logic [adll_pkg::LINK_W-1:0]  o_prev
);
    import adll_pkg::*;

    logic [LINK_W-1:0] r_next_mem [SLOTS];
    logic [LINK_W-1:0] r_prev_mem [SLOTS];
    logic [SLOTS-1:0]  r_next_vld;
    logic [SLOTS-1:0]  r_prev_vld;
    logic [LINK_W-1:0] r_next_q;
    logic [LINK_W-1:0] r_prev_q;
    logic              r_next_qv;
    logic              r_prev_qv;
    logic [SLOT_W-1:0] r_raddr_q;

    // write storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_next_wr.we) begin
            r_next_mem[i_next_wr.addr] <= i_next_wr.data;
        end
        if (i_prev_wr.we) begin
            r_prev_mem[i_prev_wr.addr] <= i_prev_wr.data;
        end
        r_next_q  <= r_next_mem[i_raddr];
        r_prev_q  <= r_prev_mem[i_raddr];
        r_raddr_q <= i_raddr;
    end

    // track written entries, capture valid with the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
            r_prev_vld <= '0;
            r_next_qv  <= 1'b0;
            r_prev_qv  <= 1'b0;
        end else begin
            r_next_qv <= r_next_vld[i_raddr];
            r_prev_qv <= r_prev_vld[i_raddr];
            if (i_next_wr.we) begin
                r_next_vld[i_next_wr.addr] <= 1'b1;
            end
            if (i_prev_wr.we) begin
                r_prev_vld[i_prev_wr.addr] <= 1'b1;
            end
        end
    end

    // unwritten next reads as slot+1, unwritten prev as null
    assign o_next = r_next_qv ? r_next_q : (LINK_W'(r_raddr_q) + LINK_W'(1));
    assign o_prev = r_prev_qv ? r_prev_q : NIL;
endmodule

FILE: rtl/adll_rec_mem.sv
// Record memory holding id and grade of each slot.
// Depends on adll_pkg.
module adll_rec_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [adll_pkg::SLOT_W-1:0] i_waddr,
    input  logic [31:0]                 i_wid,
    input  logic [31:0]                 i_wgrade,
    input  logic [adll_pkg::SLOT_W-1:0] i_raddr,
    output logic [31:0]                 o_id,
    output logic [31:0]                 o_grade
);
    import adll_pkg::*;

    logic [63:0] r_mem [SLOTS];
    logic [63:0] r_q;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wid, i_wgrade};
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_id    = r_q[63:32];
    assign o_grade = r_q[31:0];
endmodule

FILE: tb/array_doubly_linked_list_top_chk.sv
// Checker for the linked-list block: tracks the slot array and free chain,
// predicts each result and compares it with the result strobe. Uses adll_pkg.
`timescale 1ns / 1ps
module array_doubly_linked_list_top_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  adll_pkg::t_req i_req,
    input  logic           i_valid,
    input  adll_pkg::t_res i_res,
    output int             o_errors,
    output int             o_pending
);
    import adll_pkg::*;

    int          lst_head;
    int          free_top;
    int          rec_cnt;
    int          nxt [SLOTS];
    int          prv [SLOTS];
    logic [31:0] ids [SLOTS];
    logic [31:0] grades [SLOTS];
    t_res        expected_q[$];

    // find the first linked slot holding this id, or SLOTS
    function automatic int find_id(input logic [31:0] id);
        int cur;
        int steps;
        cur = lst_head;
        steps = 0;
        while (cur < SLOTS && steps < SLOTS) begin
            if (ids[cur] == id) return cur;
            cur = nxt[cur];
            steps++;
        end
        return SLOTS;
    endfunction

    // apply one request to the list image and return its result
    function automatic t_res apply_request(input t_req r);
        t_res o;
        int   nw;
        int   cur;
        int   hit;
        int   pv;
        int   nx;
        o = '0;
        case (r.req_type)
            REQ_INSERT: begin
                if (free_top >= SLOTS) begin
                    o.status = STAT_FULL;
                end else begin
                    nw = free_top;
                    free_top = nxt[nw];
                    ids[nw] = r.record_id;
                    grades[nw] = r.grade_bits;
                    nxt[nw] = SLOTS;
                    prv[nw] = SLOTS;
                    if (lst_head >= SLOTS) begin
                        lst_head = nw;
                    end else begin
                        cur = lst_head;
                        while (nxt[cur] < SLOTS) cur = nxt[cur];
                        nxt[cur] = nw;
                        prv[nw] = cur;
                    end
                    rec_cnt++;
                    o.found_slot = nw[5:0];
                end
            end
            REQ_REMOVE: begin
                hit = find_id(r.record_id);
                if (hit >= SLOTS) begin
                    o.status = STAT_MISS;
                end else begin
                    pv = prv[hit];
                    nx = nxt[hit];
                    if (pv >= SLOTS) lst_head = nx;
                    else nxt[pv] = nx;
                    if (nx < SLOTS) prv[nx] = pv;
                    nxt[hit] = free_top;
                    prv[hit] = SLOTS;
                    free_top = hit;
                    if (rec_cnt > 0) rec_cnt--;
                    o.found_slot = hit[5:0];
                end
            end
            REQ_SEARCH: begin
                hit = find_id(r.record_id);
                if (hit >= SLOTS) begin
                    o.status = STAT_MISS;
                end else begin
                    o.found_slot = hit[5:0];
                    o.found_grade = grades[hit];
                end
            end
            default: ;
        endcase
        o.element_count = rec_cnt[6:0];
        return o;
    endfunction

    assign o_pending = expected_q.size();

    // predict on each accepted transaction, compare on each result strobe
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            lst_head = SLOTS;
            free_top = 0;
            rec_cnt = 0;
            for (int i = 0; i < SLOTS; i++) begin
                nxt[i] = i + 1;
                prv[i] = SLOTS;
                ids[i] = '0;
                grades[i] = '0;
            end
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result %p", i_res);
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_res) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected %p got %p", want, i_res);
                    end
                end
            end
            if (i_start && !i_busy) expected_q.push_back(apply_request(i_req));
        end
    end
endmodule

FILE: tb/array_doubly_linked_list_top_tb.sv
// Top of the linked-list testbench: clock, reset, request stimulus and verdict.
// Depends on adll_pkg, the block and array_doubly_linked_list_top_chk.
`timescale 1ns / 1ps
module array_doubly_linked_list_top_tb;
    import adll_pkg::*;

    // request code outside the defined operations
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic  clk;
    logic  rst_n;
    logic  start;
    t_req  req;
    logic  busy;
    logic  res_valid;
    t_res  res;
    int    errors;
    int    pending;
    logic [31:0] used_ids[$];

    array_doubly_linked_list_top u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_req(req),
        .o_busy(busy), .o_valid(res_valid), .o_res(res)
    );

    array_doubly_linked_list_top_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_req(req), .i_valid(res_valid), .i_res(res),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // present one transaction and hold it until accepted
    task automatic send_request(input logic [1:0] op, input logic [31:0] id,
                                input logic [31:0] grade);
        start <= 1'b1;
        req <= '{req_type: op, record_id: id, grade_bits: grade};
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // drop start for a random gap
    task automatic idle_gap(input int n);
        start <= 1'b0;
        req <= '{req_type: 2'($urandom), record_id: $urandom, grade_bits: $urandom};
        repeat (n) @(posedge clk);
    endtask

    // ids drawn mostly from a small pool so removes and searches hit
    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'hA5A5_0000 | $urandom_range(0, 23);
        endcase
    endfunction

    initial begin
        int burst;
        int fill_bias;
        int roll;
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list misses, unknown op, extremes, fill to full
        send_request(REQ_REMOVE, 32'd5, '0);
        send_request(REQ_SEARCH, 32'hFFFF_FFFF, '0);
        send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h3F80_0000);
        send_request(REQ_SEARCH, 32'h8000_0000, '0);
        send_request(REQ_REMOVE, 32'h7FFF_FFFF, '0);
        send_request(REQ_REMOVE, 32'h8000_0000, '0);
        send_request(REQ_SEARCH, 32'h8000_0000, '0);
        send_request(REQ_SEARCH, 32'h1234_5678, '0);
        for (int i = 0; i < 66; i++) send_request(REQ_INSERT, i, $urandom);
        send_request(REQ_REMOVE, 32'd63, '0);
        send_request(REQ_REMOVE, 32'd0, '0);
        send_request(REQ_REMOVE, 32'd30, '0);
        send_request(REQ_UNKNOWN, '0, '0);

        // random: bursts with gaps, insert bias drifting so the list fills
        // and drains repeatedly
        fill_bias = 60;
        for (int n = 0; n < 950; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 950; b++, n++) begin
                if (n % 150 == 0) fill_bias = $urandom_range(20, 80);
                roll = $urandom_range(0, 99);
                if (roll < 2) send_request(REQ_UNKNOWN, $urandom, $urandom);
                else if (roll < fill_bias)
                    send_request(REQ_INSERT, pick_id(), $urandom);
                else if (roll < fill_bias + (100 - fill_bias) / 2)
                    send_request(REQ_REMOVE, pick_id(), $urandom);
                else send_request(REQ_SEARCH, pick_id(), $urandom);
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0) begin
            $display("array_doubly_linked_list_top test passed");
        end else begin
            $display("array_doubly_linked_list_top test failed");
        end
        $finish;
    end

    // stop a hung run
    initial begin
        #10_000_000;
        $display("array_doubly_linked_list_top test failed");
        $finish;
    end
endmodule
